// ===== src/lca_pkg.sv =====
// ----------------------------------------------------------------------------
// lca_pkg: shared types and constants for the life grid
// request and response beats, row-cell control, pattern rows
// ----------------------------------------------------------------------------
`default_nettype none

package lca_pkg;

    localparam int ROWS_DEF   = 64;
    localparam int COLS_DEF   = 64;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 6;
    localparam int PAT_W      = 5;
    localparam int CELL_IDX_W = 9;

    typedef enum logic [2:0] {
        REQ_CLEAR = 3'd0,
        REQ_SET   = 3'd1,
        REQ_KILL  = 3'd2,
        REQ_PLACE = 3'd3,
        REQ_STEP  = 3'd4,
        REQ_READ  = 3'd5
    } req_kind_t;

    typedef enum logic [1:0] {
        PAT_LINE   = 2'd0,
        PAT_FLOWER = 2'd1,
        PAT_GLIDER = 2'd2,
        PAT_CROSS  = 2'd3
    } pat_kind_t;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_STEP = 1'b1
    } lca_state_t;

    typedef struct packed {
        logic [2:0]       req_type;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [1:0]       pattern;
    } req_item_t;

    typedef struct packed {
        logic cell_alive;
        logic in_range;
    } rsp_item_t;

    typedef struct packed {
        logic             clear;
        logic             shift;
        logic             set_en;
        logic             kill_en;
        logic             pat_en;
        logic [ROW_W-1:0] row;
    } cell_ctrl_t;

    typedef struct packed {
        logic advance;
        logic first;
        logic last;
    } gen_ctrl_t;

    // bit k of the result is column offset k of pattern row dr
    function automatic logic [PAT_W-1:0] pat_row(input logic [1:0] pat, input logic [1:0] dr);
        logic [PAT_W-1:0] m;
        m = '0;
        case (pat)
            PAT_LINE:
            begin
                if (dr == 2'd0) m = 5'b00111;
            end
            PAT_FLOWER:
            begin
                if (dr == 2'd1) m = 5'b10101;
                else if (dr == 2'd0 || dr == 2'd2) m = 5'b01110;
            end
            PAT_GLIDER:
            begin
                if (dr == 2'd0) m = 5'b00111;
                else if (dr == 2'd1) m = 5'b00100;
                else if (dr == 2'd2) m = 5'b00010;
            end
            PAT_CROSS:
            begin
                if (dr == 2'd1) m = 5'b00111;
                else if (dr == 2'd0 || dr == 2'd2) m = 5'b00010;
            end
            default:
            begin
                m = '0;
            end
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== src/life_cellular_automaton_grid_top.sv =====
// ----------------------------------------------------------------------------
// life_cellular_automaton_grid_top: B3/S23 life grid with edit and read beats
// ROWS row cells in a chain, one next-generation unit at the chain head
// ----------------------------------------------------------------------------
// Clear, set, kill, place and read beats take effect at the accepting edge and
// their result strobes on done in the next cycle; busy stays low, so a new
// beat can follow every cycle. A step beat rotates the whole grid once through
// the row chain, one row per cycle past the generation unit: busy is high while
// the rows pass, done strobes in the cycle after the last row, and the next beat
// can be accepted in that same cycle. Results are one-cycle strobes on done;
// the receiver cannot hold them off.
// ----------------------------------------------------------------------------
`default_nettype none

module life_cellular_automaton_grid_top #(
    parameter int ROWS = lca_pkg::ROWS_DEF,
    parameter int COLS = lca_pkg::COLS_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    input  lca_pkg::req_item_t   req,
    output logic                 busy,
    output logic                 done,
    output lca_pkg::rsp_item_t   rsp
);
    import lca_pkg::*;

    localparam int CNT_W = $clog2(ROWS);
    localparam logic [CNT_W-1:0] LAST_ROW = CNT_W'(ROWS - 1);
    localparam int WIN_W = COLS + PAT_W;

    lca_state_t         state_reg;
    lca_state_t         state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               done_reg;
    logic               done_next;
    rsp_item_t          rsp_reg;
    rsp_item_t          rsp_next;

    cell_ctrl_t         cell_ctrl;
    gen_ctrl_t          gen_ctrl;
    logic               accept;
    logic               in_range_now;
    logic               read_bit;
    logic [COLS-1:0]    col_mask;
    logic [2:0][COLS-1:0] pat_mask;
    logic [COLS-1:0]    rows_q [ROWS];
    logic [COLS-1:0]    new_row;
    logic [ROWS-1:0]    read_hit;

    assign busy   = (state_reg == ST_STEP);
    assign accept = start && !busy;

    assign in_range_now = (int'(req.row) < ROWS) && (int'(req.col) < COLS);

    // one-hot column; a column past the grid shifts out to all zeros
    assign col_mask = {{(COLS-1){1'b0}}, 1'b1} << req.col;

    // pattern rows moved to the origin column, cells past the edge dropped
    always_comb
    begin
        logic [WIN_W-1:0] win;
        for (int dr = 0; dr < 3; dr++)
        begin
            win = {{COLS{1'b0}}, pat_row(req.pattern, 2'(dr))} << req.col;
            pat_mask[dr] = win[COLS-1:0];
        end
    end

    // row chain
    genvar gi;
    generate
        for (gi = 0; gi < ROWS; gi++)
        begin : g_row
            logic [COLS-1:0] shift_in;
            if (gi == ROWS - 1)
            begin : g_tail
                assign shift_in = new_row;
            end
            else
            begin : g_mid
                assign shift_in = rows_q[gi+1];
            end

            lca_cell #(
                .COLS (COLS),
                .IDX  (gi)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (cell_ctrl),
                .col_mask (col_mask),
                .pat_mask (pat_mask),
                .shift_in (shift_in),
                .row_out  (rows_q[gi])
            );

            assign read_hit[gi] = (int'(req.row) == gi) && |(rows_q[gi] & col_mask);
        end
    endgenerate

    assign read_bit = |read_hit;

    assign gen_ctrl.advance = cell_ctrl.shift;
    assign gen_ctrl.first   = (cnt_reg == '0);
    assign gen_ctrl.last    = (cnt_reg == LAST_ROW);

    lca_gen #(
        .COLS (COLS)
    ) u_gen (
        .clk     (clk),
        .ctrl    (gen_ctrl),
        .center  (rows_q[0]),
        .below   (rows_q[1]),
        .new_row (new_row)
    );

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        done_next     = 1'b0;
        rsp_next      = rsp_reg;
        cell_ctrl     = '0;
        cell_ctrl.row = req.row;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rsp_next.in_range   = in_range_now;
                    rsp_next.cell_alive = 1'b0;
                    done_next           = 1'b1;
                    case (req.req_type)
                        REQ_CLEAR: cell_ctrl.clear   = 1'b1;
                        REQ_SET:   cell_ctrl.set_en  = 1'b1;
                        REQ_KILL:  cell_ctrl.kill_en = 1'b1;
                        REQ_PLACE: cell_ctrl.pat_en  = 1'b1;
                        REQ_STEP:
                        begin
                            state_next = ST_STEP;
                            cnt_next   = '0;
                            done_next  = 1'b0;
                        end
                        REQ_READ:  rsp_next.cell_alive = in_range_now && read_bit;
                        default:   rsp_next.cell_alive = 1'b0;
                    endcase
                end
            end
            ST_STEP:
            begin
                cell_ctrl.shift = 1'b1;
                cnt_next        = cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST_ROW)
                begin
                    state_next = ST_IDLE;
                    cnt_next   = '0;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // no result while the grid is rotating
    a_no_done_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
        else $error("result strobe during generation step");

    a_step_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.req_type == REQ_STEP) |=> busy)
        else $error("step beat did not start rotation");

    a_step_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("generation step ended without result");

    a_alive_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.cell_alive) |-> rsp.in_range)
        else $error("live read of a cell outside the grid");

endmodule

`default_nettype wire

// ===== src/lca_cell.sv =====
// ----------------------------------------------------------------------------
// lca_cell: one grid row in the row chain
// holds COLS cells, takes edits for its own row index, shifts to its neighbor
// ----------------------------------------------------------------------------
`default_nettype none

module lca_cell #(
    parameter int COLS = lca_pkg::COLS_DEF,
    parameter int IDX  = 0
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  lca_pkg::cell_ctrl_t       ctrl,
    input  wire  [COLS-1:0]           col_mask,
    input  wire  [2:0][COLS-1:0]      pat_mask,
    input  wire  [COLS-1:0]           shift_in,
    output logic [COLS-1:0]           row_out
);
    import lca_pkg::*;

    localparam logic [CELL_IDX_W-1:0] MY_IDX = CELL_IDX_W'(IDX);

    logic [COLS-1:0]       row_reg;
    logic [COLS-1:0]       row_next;
    logic [CELL_IDX_W-1:0] base;
    logic                  hit0;
    logic                  hit1;
    logic                  hit2;
    logic [COLS-1:0]       pat_sel;

    assign base = CELL_IDX_W'(ctrl.row);
    assign hit0 = (MY_IDX == base);
    assign hit1 = (MY_IDX == base + CELL_IDX_W'(1));
    assign hit2 = (MY_IDX == base + CELL_IDX_W'(2));

    // pattern row that lands on this grid row, if any
    assign pat_sel = ({COLS{hit0}} & pat_mask[0])
                   | ({COLS{hit1}} & pat_mask[1])
                   | ({COLS{hit2}} & pat_mask[2]);

    always_comb
    begin
        row_next = row_reg;
        if (ctrl.clear)
            row_next = '0;
        else if (ctrl.shift)
            row_next = shift_in;
        else if (ctrl.set_en && hit0)
            row_next = row_reg | col_mask;
        else if (ctrl.kill_en && hit0)
            row_next = row_reg & ~col_mask;
        else if (ctrl.pat_en)
            row_next = row_reg | pat_sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_reg <= '0;
        else
            row_reg <= row_next;
    end

    assign row_out = row_reg;

endmodule

`default_nettype wire

// ===== src/lca_gen.sv =====
// ----------------------------------------------------------------------------
// lca_gen: next-generation row unit at the head of the row chain
// keeps the previous old row as line buffer, applies B3/S23 per column
// ----------------------------------------------------------------------------
`default_nettype none

module lca_gen #(
    parameter int COLS = lca_pkg::COLS_DEF
) (
    input  wire                   clk,
    input  lca_pkg::gen_ctrl_t    ctrl,
    input  wire  [COLS-1:0]       center,
    input  wire  [COLS-1:0]       below,
    output logic [COLS-1:0]       new_row
);
    import lca_pkg::*;

    logic [COLS-1:0] above_reg;
    logic [COLS+1:0] pa;
    logic [COLS+1:0] pc;
    logic [COLS+1:0] pb;

    // old row above the one at the head
    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
            above_reg <= center;
    end

    // zero padding stands for the dead cells beyond every edge
    assign pa = {1'b0, (ctrl.first ? {COLS{1'b0}} : above_reg), 1'b0};
    assign pc = {1'b0, center, 1'b0};
    assign pb = {1'b0, (ctrl.last ? {COLS{1'b0}} : below), 1'b0};

    always_comb
    begin
        logic [3:0] n;
        new_row = '0;
        for (int c = 0; c < COLS; c++)
        begin
            n = 4'(pa[c]) + 4'(pa[c+1]) + 4'(pa[c+2])
              + 4'(pc[c]) + 4'(pc[c+2])
              + 4'(pb[c]) + 4'(pb[c+1]) + 4'(pb[c+2]);
            new_row[c] = (n == 4'd3) || (pc[c+1] && n == 4'd2);
        end
    end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the life grid
// edits, seeds, generations and reads go through the command port; a software
// copy of the grid predicts every done beat, which is checked field by field
// ----------------------------------------------------------------------------

module tb;
    import lca_pkg::*;

    localparam int GRID_ROWS     = ROWS_DEF;
    localparam int GRID_COLS     = COLS_DEF;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = GRID_ROWS + 8;
    localparam int RANDOM_BEATS  = 630;

    // request codes the block does not define
    localparam logic [2:0] REQ_SPARE6 = 3'd6;
    localparam logic [2:0] REQ_SPARE7 = 3'd7;

    logic      clk   = 1'b0;
    logic      rst_n;
    logic      start = 1'b0;
    req_item_t req   = '0;
    logic      busy;
    logic      done;
    rsp_item_t rsp;

    logic [GRID_COLS-1:0] life_grid [GRID_ROWS];
    rsp_item_t            pending_rsp_q [$];
    int                   errors     = 0;
    int                   cycles     = 0;
    int                   burst_left = 0;
    int                   max_gap    = 4;
    int                   focus_row  = 0;
    int                   focus_col  = 0;

    life_cellular_automaton_grid_top #(
        .ROWS (GRID_ROWS),
        .COLS (GRID_COLS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // grid model
    // ------------------------------------------------------------------
    function automatic void mark_alive(int r, int c);
        if (r < GRID_ROWS && c < GRID_COLS)
            life_grid[r][c] = 1'b1;
    endfunction

    function automatic void place_seed(logic [1:0] p, int r, int c);
        case (p)
            PAT_LINE:
            begin
                mark_alive(r, c);     mark_alive(r, c + 1); mark_alive(r, c + 2);
            end
            PAT_FLOWER:
            begin
                mark_alive(r, c + 1);     mark_alive(r, c + 2);     mark_alive(r, c + 3);
                mark_alive(r + 1, c);     mark_alive(r + 1, c + 2); mark_alive(r + 1, c + 4);
                mark_alive(r + 2, c + 1); mark_alive(r + 2, c + 2); mark_alive(r + 2, c + 3);
            end
            PAT_GLIDER:
            begin
                mark_alive(r, c);         mark_alive(r, c + 1);     mark_alive(r, c + 2);
                mark_alive(r + 1, c + 2); mark_alive(r + 2, c + 1);
            end
            default:
            begin
                mark_alive(r, c + 1);     mark_alive(r + 1, c);     mark_alive(r + 1, c + 1);
                mark_alive(r + 1, c + 2); mark_alive(r + 2, c + 1);
            end
        endcase
    endfunction

    // counts come from the generation before, never from the rows being rewritten
    function automatic void next_generation();
        logic [GRID_COLS-1:0] prev [GRID_ROWS];
        int r;
        int c;
        int dr;
        int dc;
        int rr;
        int cc;
        int n;
        prev = life_grid;
        for (r = 0; r < GRID_ROWS; r++)
        begin
            for (c = 0; c < GRID_COLS; c++)
            begin
                n = 0;
                for (dr = -1; dr <= 1; dr++)
                begin
                    for (dc = -1; dc <= 1; dc++)
                    begin
                        rr = r + dr;
                        cc = c + dc;
                        if ((dr != 0 || dc != 0) && rr >= 0 && rr < GRID_ROWS &&
                            cc >= 0 && cc < GRID_COLS)
                            n += prev[rr][cc];
                    end
                end
                if (!prev[r][c])
                begin
                    if (n == 3)
                        life_grid[r][c] = 1'b1;
                end
                else if (n < 2 || n >= 4)
                begin
                    life_grid[r][c] = 1'b0;
                end
            end
        end
    endfunction

    function automatic rsp_item_t apply_request(req_item_t it);
        rsp_item_t r;
        logic      ok;
        int        i;
        ok           = (int'(it.row) < GRID_ROWS) && (int'(it.col) < GRID_COLS);
        r.cell_alive = 1'b0;
        r.in_range   = ok;
        case (it.req_type)
            REQ_CLEAR:
            begin
                for (i = 0; i < GRID_ROWS; i++)
                    life_grid[i] = '0;
            end
            REQ_SET:
            begin
                if (ok) life_grid[it.row][it.col] = 1'b1;
            end
            REQ_KILL:
            begin
                if (ok) life_grid[it.row][it.col] = 1'b0;
            end
            REQ_PLACE:
            begin
                place_seed(it.pattern, int'(it.row), int'(it.col));
            end
            REQ_STEP:
            begin
                next_generation();
            end
            REQ_READ:
            begin
                if (ok) r.cell_alive = life_grid[it.row][it.col];
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic req_item_t make_req(logic [2:0] k, int r, int c, logic [1:0] p);
        req_item_t it;
        it.req_type = k;
        it.row      = r[ROW_W-1:0];
        it.col      = c[COL_W-1:0];
        it.pattern  = p;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // driving; every task is entered and left just after a rising edge
    // ------------------------------------------------------------------
    task automatic send_beat(input req_item_t item);
        rsp_item_t want;
        start <= 1'b1;
        req   <= item;
        @(posedge clk);
        while (busy) @(posedge clk);
        want = apply_request(item);
        pending_rsp_q.push_back(want);
    endtask

    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 9) == 0)
                gap = $urandom_range(20, 80);   // long idle gap between bursts
            else
                gap = $urandom_range(0, max_gap);
            if (max_gap == 0)
                gap = 0;
            if (gap > 0)
            begin
                if (start)
                    start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic issue(input logic [2:0] k, input int r, input int c, input logic [1:0] p);
        pace();
        send_beat(make_req(k, r, c, p));
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_rsp_q.size() != 0) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_cell_edits();
        issue(REQ_SET,  0,  0,  PAT_LINE);
        issue(REQ_SET,  63, 63, PAT_CROSS);
        issue(REQ_SET,  0,  63, PAT_FLOWER);
        issue(REQ_READ, 0,  0,  PAT_LINE);
        issue(REQ_READ, 63, 63, PAT_CROSS);
        issue(REQ_READ, 63, 0,  PAT_GLIDER);
        issue(REQ_KILL, 0,  0,  PAT_CROSS);
        issue(REQ_READ, 0,  0,  PAT_LINE);
    endtask

    task automatic test_seed_patterns();
        issue(REQ_CLEAR, 0,  0,  PAT_LINE);
        issue(REQ_PLACE, 10, 10, PAT_LINE);
        issue(REQ_PLACE, 20, 20, PAT_FLOWER);
        issue(REQ_PLACE, 40, 5,  PAT_GLIDER);
        issue(REQ_PLACE, 5,  40, PAT_CROSS);
        // seed hanging over the bottom right corner
        issue(REQ_PLACE, 62, 61, PAT_FLOWER);
        issue(REQ_READ,  63, 62, PAT_LINE);
    endtask

    task automatic test_generation();
        issue(REQ_STEP, 0,  0,  PAT_LINE);
        issue(REQ_READ, 9,  11, PAT_LINE);
        issue(REQ_READ, 10, 10, PAT_LINE);
        issue(REQ_STEP, 63, 63, PAT_CROSS);
        issue(REQ_READ, 10, 10, PAT_LINE);
    endtask

    task automatic test_spare_kinds();
        issue(REQ_SPARE6, 63, 0,  PAT_CROSS);
        issue(REQ_SPARE7, 0,  63, PAT_GLIDER);
        issue(REQ_CLEAR,  63, 63, PAT_CROSS);
        issue(REQ_READ,   63, 62, PAT_LINE);
    endtask

    task automatic test_random_traffic(input int count);
        int i;
        int v;
        int r;
        int c;
        for (i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
            begin
                v = $urandom_range(0, 2);
                max_gap = (v == 0) ? 0 : ((v == 1) ? 3 : 12);
            end
            if (i == count / 2)
                drain();
            v = $urandom_range(0, 99);
            if ($urandom_range(0, 3) != 0)
            begin
                r = (focus_row + $urandom_range(0, 6) + 63) % 64;
                c = (focus_col + $urandom_range(0, 6) + 63) % 64;
            end
            else
            begin
                r = $urandom_range(0, 63);
                c = $urandom_range(0, 63);
            end
            if (v < 3)
                issue(REQ_CLEAR, r, c, 2'($urandom_range(0, 3)));
            else if (v < 6)
                issue($urandom_range(0, 1) ? REQ_SPARE6 : REQ_SPARE7, r, c,
                      2'($urandom_range(0, 3)));
            else if (v < 20)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    focus_row = $urandom_range(58, 63);
                    focus_col = $urandom_range(0, 1) ? $urandom_range(58, 63)
                                                     : $urandom_range(0, 63);
                end
                else
                begin
                    focus_row = $urandom_range(0, 63);
                    focus_col = $urandom_range(0, 63);
                end
                issue(REQ_PLACE, focus_row, focus_col, 2'($urandom_range(0, 3)));
            end
            else if (v < 32)
                issue(REQ_SET, r, c, 2'($urandom_range(0, 3)));
            else if (v < 40)
                issue(REQ_KILL, r, c, 2'($urandom_range(0, 3)));
            else if (v < 50)
                issue(REQ_STEP, r, c, 2'($urandom_range(0, 3)));
            else
                issue(REQ_READ, r, c, 2'($urandom_range(0, 3)));
        end
    endtask

    // ------------------------------------------------------------------
    // result checking and watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : rsp_check
        rsp_item_t want;
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("CHECKS FAILED");
            $finish;
        end
        else if (rst_n && done === 1'b1)
        begin
            if (pending_rsp_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual %b/%b",
                         $time, rsp.cell_alive, rsp.in_range);
            end
            else
            begin
                want = pending_rsp_q.pop_front();
                if (rsp.cell_alive !== want.cell_alive)
                begin
                    errors++;
                    $display("%0t: cell_alive mismatch, expected %b, actual %b",
                             $time, want.cell_alive, rsp.cell_alive);
                end
                if (rsp.in_range !== want.in_range)
                begin
                    errors++;
                    $display("%0t: in_range mismatch, expected %b, actual %b",
                             $time, want.in_range, rsp.in_range);
                end
            end
        end
    end

    initial
    begin : run
        int i;
        for (i = 0; i < GRID_ROWS; i++)
            life_grid[i] = '0;
        // driven after time zero starts so the asynchronous reset sees a falling edge
        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_cell_edits();
        test_seed_patterns();
        test_generation();
        test_spare_kinds();
        drain();
        test_random_traffic(RANDOM_BEATS);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && pending_rsp_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
